// ===== design/arqg_pkg.sv =====
// Package: shared types, widths and codes for the audio recording quality gate.
`timescale 1ns / 1ps

package arqg_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int LEVEL_W    = 16;
    localparam int PCT_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int QUAL_W     = 2;
    localparam int OUT_CNT_W  = 21;
    localparam int OUT_BLK_W  = 13;
    localparam int OUT_SQ_W   = 51;
    localparam int MUL_B_W    = 17;
    localparam int SPLIT_W    = 17;
    localparam int SQ_TERM_W  = 31;
    localparam int RMS2_W     = 32;

    localparam logic [OUT_BLK_W-1:0] BLK_CNT_MAX = 13'd4096;
    localparam logic [MUL_B_W-1:0]   PCT_SCALE   = 17'd100;

    localparam logic [LEVEL_W-1:0] CLIP_LEVEL_RST       = 16'd32000;
    localparam logic [LEVEL_W-1:0] ACTIVE_THRESHOLD_RST = 16'd80;
    localparam logic [LEVEL_W-1:0] MIN_RMS_RST          = 16'd150;
    localparam logic [PCT_W-1:0]   MIN_ACTIVE_PCT_RST   = 7'd5;
    localparam logic [PCT_W-1:0]   MAX_CLIPPED_PCT_RST  = 7'd1;

    localparam logic [CFG_IDX_W-1:0] REG_CLIP_LEVEL       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RMS          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_ACTIVE_PCT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CLIPPED_PCT  = 3'd4;

    localparam logic [QUAL_W-1:0] QUALITY_OK       = 2'd0;
    localparam logic [QUAL_W-1:0] QUALITY_WEAK     = 2'd1;
    localparam logic [QUAL_W-1:0] QUALITY_LOUD     = 2'd2;
    localparam logic [QUAL_W-1:0] QUALITY_INACTIVE = 2'd3;

    typedef struct packed {
        logic [LEVEL_W-1:0] clip_level;
        logic [LEVEL_W-1:0] active_threshold;
        logic [LEVEL_W-1:0] min_rms;
        logic [PCT_W-1:0]   min_active_pct;
        logic [PCT_W-1:0]   max_clipped_pct;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_ACC,
        S_BLK,
        S_BCHK,
        S_F_ACT,
        S_F_ACT2,
        S_F_CLIP,
        S_F_CLIP2,
        S_F_RMS,
        S_F_RMS2,
        S_F_HI,
        S_F_SUM,
        S_F_OUT
    } state_t;

endpackage

// ===== design/arqg_cfg.sv =====
// Configuration register file with write handshake.
`timescale 1ns / 1ps

module arqg_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [arqg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [arqg_pkg::CFG_DATA_W-1:0] cfg_data,
    output arqg_pkg::cfg_t                 cfg
);
    import arqg_pkg::*;

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.clip_level       <= CLIP_LEVEL_RST;
            cfg_reg.active_threshold <= ACTIVE_THRESHOLD_RST;
            cfg_reg.min_rms          <= MIN_RMS_RST;
            cfg_reg.min_active_pct   <= MIN_ACTIVE_PCT_RST;
            cfg_reg.max_clipped_pct  <= MAX_CLIPPED_PCT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CLIP_LEVEL:       cfg_reg.clip_level       <= cfg_data;
                REG_ACTIVE_THRESHOLD: cfg_reg.active_threshold <= cfg_data;
                REG_MIN_RMS:          cfg_reg.min_rms          <= cfg_data;
                REG_MIN_ACTIVE_PCT:   cfg_reg.min_active_pct   <= cfg_data[PCT_W-1:0];
                REG_MAX_CLIPPED_PCT:  cfg_reg.max_clipped_pct  <= cfg_data[PCT_W-1:0];
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

endmodule

// ===== design/arqg_mul.sv =====
// Shared unsigned multiplier with registered product.
`timescale 1ns / 1ps

module arqg_mul #(
    parameter int A_W = 32,
    parameter int B_W = 17
) (
    input  logic               clk,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic [A_W+B_W-1:0] p
);
    logic [A_W+B_W-1:0] p_reg;

    assign p = p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
    end

endmodule

// ===== design/audio_recording_quality_gate.sv =====
// Top level: sample sequencer, recording accumulators and result register.
// Each sample passes S_SQ and S_ACC, then S_BLK and S_BCHK when it closes a block;
// after a last sample, S_F_ACT to S_F_OUT form the result, held while it stalls.
// A new sample is accepted only in S_IDLE, once the previous one is finished.
// Reset (rst_n, asynchronous, active low) clears the sequencer, accumulators and
// result valid, and loads the configuration registers with their defaults.
`timescale 1ns / 1ps

module audio_recording_quality_gate #(
    parameter int BLOCK_SIZE  = 256,
    parameter int COUNT_WIDTH = 20
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [arqg_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [arqg_pkg::CFG_DATA_W-1:0]        cfg_data,
    input  logic                                  sample_valid,
    output logic                                  sample_ready,
    input  logic signed [arqg_pkg::SAMPLE_W-1:0]   sample,
    input  logic                                  last,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic [arqg_pkg::QUAL_W-1:0]            quality,
    output logic [arqg_pkg::LEVEL_W-1:0]           peak,
    output logic [arqg_pkg::OUT_CNT_W-1:0]         clipped_count,
    output logic [arqg_pkg::OUT_BLK_W-1:0]         active_count,
    output logic [arqg_pkg::OUT_BLK_W-1:0]         block_count,
    output logic [arqg_pkg::OUT_SQ_W-1:0]          sum_squares,
    output logic [arqg_pkg::OUT_CNT_W-1:0]         sample_count
);
    import arqg_pkg::*;

    localparam int CNT_W  = COUNT_WIDTH + 1;
    localparam int SQ_W   = COUNT_WIDTH + 31;
    localparam int POS_W  = $clog2(BLOCK_SIZE + 1);
    localparam int BA_W   = SAMPLE_W + $clog2(BLOCK_SIZE);
    localparam int MA_W   = (CNT_W > RMS2_W) ? CNT_W : RMS2_W;
    localparam int P_W    = MA_W + MUL_B_W;
    localparam int FULL_W = P_W + SPLIT_W;
    localparam int SX_W   = 2 * SPLIT_W;
    localparam int XC_W   = (CNT_W > OUT_CNT_W) ? CNT_W : OUT_CNT_W;
    localparam int XS_W   = (SQ_W > OUT_SQ_W) ? SQ_W : OUT_SQ_W;

    localparam logic [SQ_W-1:0]  SQ_MAX     = SQ_W'(1) << (COUNT_WIDTH + 30);
    localparam logic [CNT_W-1:0] SAMPLE_MAX = CNT_W'(1) << COUNT_WIDTH;
    localparam logic [POS_W-1:0] BLOCK_LEN  = POS_W'(BLOCK_SIZE);

    cfg_t cfg;

    logic [MA_W-1:0]    mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [P_W-1:0]     mul_p;

    state_t              state_reg, state_next;
    logic [SQ_W-1:0]     sq_acc_reg, sq_acc_next;
    logic [LEVEL_W-1:0]  peak_reg, peak_next;
    logic [CNT_W-1:0]    clip_reg, clip_next;
    logic [CNT_W-1:0]    samples_reg, samples_next;
    logic [BA_W-1:0]     babs_reg, babs_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [OUT_BLK_W-1:0] active_reg, active_next;
    logic [OUT_BLK_W-1:0] blocks_reg, blocks_next;
    logic                result_valid_reg, result_valid_next;

    logic [LEVEL_W-1:0]  mag_reg, mag_next;
    logic                last_reg, last_next;
    logic [POS_W-1:0]    close_len_reg, close_len_next;
    logic [P_W-1:0]      p1_reg, p1_next;
    logic                inactive_reg, inactive_next;
    logic                loud_reg, loud_next;
    logic [RMS2_W-1:0]   rms2_reg, rms2_next;
    logic [FULL_W-1:0]   full_reg, full_next;

    logic [QUAL_W-1:0]    quality_reg, quality_next;
    logic [LEVEL_W-1:0]   peak_out_reg, peak_out_next;
    logic [OUT_CNT_W-1:0] clip_out_reg, clip_out_next;
    logic [OUT_BLK_W-1:0] active_out_reg, active_out_next;
    logic [OUT_BLK_W-1:0] blocks_out_reg, blocks_out_next;
    logic [OUT_SQ_W-1:0]  sq_out_reg, sq_out_next;
    logic [OUT_CNT_W-1:0] samples_out_reg, samples_out_next;

    logic [SAMPLE_W-1:0] raw;
    logic [SQ_W-1:0]     sq_sum;
    logic [POS_W-1:0]    pos_inc;
    logic [SX_W-1:0]     samp_x;
    logic [XC_W-1:0]     clip_x;
    logic [XC_W-1:0]     samples_x;
    logic [XS_W-1:0]     sq_x;
    logic                rms_low;

    arqg_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    arqg_mul #(
        .A_W (MA_W),
        .B_W (MUL_B_W)
    ) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign raw       = sample;
    assign sq_sum    = sq_acc_reg + SQ_W'(mul_p[SQ_TERM_W-1:0]);
    assign pos_inc   = pos_reg + POS_W'(1);
    assign samp_x    = SX_W'(samples_reg);
    assign clip_x    = XC_W'(clip_reg);
    assign samples_x = XC_W'(samples_reg);
    assign sq_x      = XS_W'(sq_acc_reg);
    assign rms_low   = FULL_W'(sq_acc_reg) < full_reg;

    assign sample_ready  = (state_reg == S_IDLE);
    assign result_valid  = result_valid_reg;
    assign quality       = quality_reg;
    assign peak          = peak_out_reg;
    assign clipped_count = clip_out_reg;
    assign active_count  = active_out_reg;
    assign block_count   = blocks_out_reg;
    assign sum_squares   = sq_out_reg;
    assign sample_count  = samples_out_reg;

    always_comb
    begin
        state_next        = state_reg;
        sq_acc_next       = sq_acc_reg;
        peak_next         = peak_reg;
        clip_next         = clip_reg;
        samples_next      = samples_reg;
        babs_next         = babs_reg;
        pos_next          = pos_reg;
        active_next       = active_reg;
        blocks_next       = blocks_reg;
        result_valid_next = result_valid_reg && !result_ready;
        mag_next          = mag_reg;
        last_next         = last_reg;
        close_len_next    = close_len_reg;
        p1_next           = p1_reg;
        inactive_next     = inactive_reg;
        loud_next         = loud_reg;
        rms2_next         = rms2_reg;
        full_next         = full_reg;
        quality_next      = quality_reg;
        peak_out_next     = peak_out_reg;
        clip_out_next     = clip_out_reg;
        active_out_next   = active_out_reg;
        blocks_out_next   = blocks_out_reg;
        sq_out_next       = sq_out_reg;
        samples_out_next  = samples_out_reg;
        mul_a             = '0;
        mul_b             = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    mag_next   = raw[SAMPLE_W-1] ? (~raw + SAMPLE_W'(1)) : raw;
                    last_next  = last;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                mul_a      = MA_W'(mag_reg);
                mul_b      = MUL_B_W'(mag_reg);
                state_next = S_ACC;
            end
            S_ACC:
            begin
                sq_acc_next = (sq_sum >= SQ_MAX) ? SQ_MAX : sq_sum;
                if (mag_reg > peak_reg)
                begin
                    peak_next = mag_reg;
                end
                if (mag_reg > cfg.clip_level && clip_reg < SAMPLE_MAX)
                begin
                    clip_next = clip_reg + CNT_W'(1);
                end
                if (samples_reg < SAMPLE_MAX)
                begin
                    samples_next = samples_reg + CNT_W'(1);
                end
                babs_next = babs_reg + BA_W'(mag_reg);
                if (pos_inc == BLOCK_LEN || last_reg)
                begin
                    close_len_next = pos_inc;
                    pos_next       = '0;
                    state_next     = S_BLK;
                end
                else
                begin
                    pos_next   = pos_inc;
                    state_next = S_IDLE;
                end
            end
            S_BLK:
            begin
                mul_a      = MA_W'(close_len_reg);
                mul_b      = MUL_B_W'(cfg.active_threshold) + MUL_B_W'(1);
                state_next = S_BCHK;
            end
            S_BCHK:
            begin
                if (blocks_reg < BLK_CNT_MAX)
                begin
                    blocks_next = blocks_reg + OUT_BLK_W'(1);
                    if (P_W'(babs_reg) >= mul_p)
                    begin
                        active_next = active_reg + OUT_BLK_W'(1);
                    end
                end
                babs_next  = '0;
                state_next = last_reg ? S_F_ACT : S_IDLE;
            end
            S_F_ACT:
            begin
                mul_a      = MA_W'(active_reg);
                mul_b      = PCT_SCALE;
                state_next = S_F_ACT2;
            end
            S_F_ACT2:
            begin
                p1_next    = mul_p;
                mul_a      = MA_W'(blocks_reg);
                mul_b      = MUL_B_W'(cfg.min_active_pct);
                state_next = S_F_CLIP;
            end
            S_F_CLIP:
            begin
                inactive_next = p1_reg < mul_p;
                mul_a         = MA_W'(clip_reg);
                mul_b         = PCT_SCALE;
                state_next    = S_F_CLIP2;
            end
            S_F_CLIP2:
            begin
                p1_next    = mul_p;
                mul_a      = MA_W'(samples_reg);
                mul_b      = MUL_B_W'(cfg.max_clipped_pct);
                state_next = S_F_RMS;
            end
            S_F_RMS:
            begin
                loud_next  = p1_reg > mul_p;
                mul_a      = MA_W'(cfg.min_rms);
                mul_b      = MUL_B_W'(cfg.min_rms);
                state_next = S_F_RMS2;
            end
            S_F_RMS2:
            begin
                rms2_next  = mul_p[RMS2_W-1:0];
                mul_a      = MA_W'(mul_p[RMS2_W-1:0]);
                mul_b      = samp_x[SPLIT_W-1:0];
                state_next = S_F_HI;
            end
            S_F_HI:
            begin
                p1_next    = mul_p;
                mul_a      = MA_W'(rms2_reg);
                mul_b      = samp_x[SX_W-1:SPLIT_W];
                state_next = S_F_SUM;
            end
            S_F_SUM:
            begin
                full_next  = FULL_W'(p1_reg) + (FULL_W'(mul_p) << SPLIT_W);
                state_next = S_F_OUT;
            end
            S_F_OUT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    if (inactive_reg)
                    begin
                        quality_next = QUALITY_INACTIVE;
                    end
                    else if (loud_reg)
                    begin
                        quality_next = QUALITY_LOUD;
                    end
                    else if (rms_low)
                    begin
                        quality_next = QUALITY_WEAK;
                    end
                    else
                    begin
                        quality_next = QUALITY_OK;
                    end
                    peak_out_next     = peak_reg;
                    clip_out_next     = clip_x[OUT_CNT_W-1:0];
                    active_out_next   = active_reg;
                    blocks_out_next   = blocks_reg;
                    sq_out_next       = sq_x[OUT_SQ_W-1:0];
                    samples_out_next  = samples_x[OUT_CNT_W-1:0];
                    result_valid_next = 1'b1;
                    sq_acc_next       = '0;
                    peak_next         = '0;
                    clip_next         = '0;
                    samples_next      = '0;
                    babs_next         = '0;
                    pos_next          = '0;
                    active_next       = '0;
                    blocks_next       = '0;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            sq_acc_reg       <= '0;
            peak_reg         <= '0;
            clip_reg         <= '0;
            samples_reg      <= '0;
            babs_reg         <= '0;
            pos_reg          <= '0;
            active_reg       <= '0;
            blocks_reg       <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sq_acc_reg       <= sq_acc_next;
            peak_reg         <= peak_next;
            clip_reg         <= clip_next;
            samples_reg      <= samples_next;
            babs_reg         <= babs_next;
            pos_reg          <= pos_next;
            active_reg       <= active_next;
            blocks_reg       <= blocks_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg         <= mag_next;
        last_reg        <= last_next;
        close_len_reg   <= close_len_next;
        p1_reg          <= p1_next;
        inactive_reg    <= inactive_next;
        loud_reg        <= loud_next;
        rms2_reg        <= rms2_next;
        full_reg        <= full_next;
        quality_reg     <= quality_next;
        peak_out_reg    <= peak_out_next;
        clip_out_reg    <= clip_out_next;
        active_out_reg  <= active_out_next;
        blocks_out_reg  <= blocks_out_next;
        sq_out_reg      <= sq_out_next;
        samples_out_reg <= samples_out_next;
    end

endmodule

// ===== design/arqg_checker.sv =====
// Port-level checker for the quality gate and its bind to the top level.
`timescale 1ns / 1ps

module arqg_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  cfg_valid,
    input logic                                  cfg_ready,
    input logic [arqg_pkg::CFG_IDX_W-1:0]         cfg_index,
    input logic [arqg_pkg::CFG_DATA_W-1:0]        cfg_data,
    input logic                                  sample_valid,
    input logic                                  sample_ready,
    input logic signed [arqg_pkg::SAMPLE_W-1:0]   sample,
    input logic                                  last,
    input logic                                  result_valid,
    input logic                                  result_ready,
    input logic [arqg_pkg::QUAL_W-1:0]            quality,
    input logic [arqg_pkg::LEVEL_W-1:0]           peak,
    input logic [arqg_pkg::OUT_CNT_W-1:0]         clipped_count,
    input logic [arqg_pkg::OUT_BLK_W-1:0]         active_count,
    input logic [arqg_pkg::OUT_BLK_W-1:0]         block_count,
    input logic [arqg_pkg::OUT_SQ_W-1:0]          sum_squares,
    input logic [arqg_pkg::OUT_CNT_W-1:0]         sample_count
);
    import arqg_pkg::*;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(quality))
    else $error("result word dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
    else $error("sample accepted while previous word still in work");

    a_active_le_total: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> active_count <= block_count)
    else $error("active block count above total block count");

    a_blocks_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> block_count != '0)
    else $error("result with no closed block");

endmodule

bind audio_recording_quality_gate arqg_checker u_arqg_checker (.*);
